[hdl/dmchc_pkg.sv]
// shared types, constants and codes for the direct-mapped cache hit counter
// no dependencies; imported by every module of the block except dmchc_ram
package dmchc_pkg;

    // field widths fixed by the transaction format
    localparam int ADDR_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int TAG_W        = 30;
    localparam int IDX_FIELD_W  = 4;
    localparam int WOFS_W       = 3;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 4;

    // masked block index before folding into the line range
    localparam int SEL_W        = 15;
    // reciprocal scaling used to fold the index into the line range
    localparam int RECIP_SHIFT  = 30;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int PROD_W       = SEL_W + RECIP_W;

    // defaults for the top level parameters
    localparam int DEF_LINES        = 512;
    localparam int DEF_ADDRESS_BITS = 32;

    // opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_OFFSET = 1'b1;

    // configuration reset values
    localparam logic [IDX_FIELD_W-1:0] INDEX_BITS_RESET  = 4'd9;
    localparam logic [WOFS_W-1:0]      WORD_OFFSET_RESET = 3'd0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // request transaction
    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
    } dmchc_req_t;

    // result transaction
    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
    } dmchc_resp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic zero_counts;
        logic sweep;
        logic split;
        logic scale;
        logic fold;
        logic lookup;
        logic update;
        logic finish_flush;
    } dmchc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic flush_req;
        logic sweep_last;
    } dmchc_status_t;

endpackage

[hdl/direct_mapped_cache_hit_counter.sv]
// Direct-mapped cache tag store that counts hits and misses. An access
// transaction is accepted when start is high and busy is low; its result
// appears for one cycle with done high, and the next transaction can be
// accepted in that same cycle, so each access is through before the next
// is taken (address split, reciprocal multiply, remainder, tag ram read,
// compare and write). A flush transaction clears the tag store with a
// sweep that writes one line per cycle through the single ram write port;
// its result (hit low, counts zero) comes with done once the sweep ends.
// After reset the same sweep runs with busy high. Results cannot be held
// off, so the receiver must take done as it comes. Config writes are taken
// at any time but belong in idle periods.
// top level: depends on dmchc_pkg, dmchc_ctrl, dmchc_datapath, dmchc_ram
module direct_mapped_cache_hit_counter
    import dmchc_pkg::*;
#(
    parameter int LINES        = DEF_LINES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  dmchc_req_t             request,
    output logic                   done,
    output dmchc_resp_t            result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dmchc_cmd_t    cmd;
    dmchc_status_t status;

    // sequencing
    dmchc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // storage and arithmetic
    dmchc_datapath #(
        .LINES        (LINES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

[hdl/dmchc_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module dmchc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/dmchc_datapath.sv]
// datapath: config registers, address split, line folding, tag store,
// counters and result register; depends on dmchc_pkg and dmchc_ram
module dmchc_datapath
    import dmchc_pkg::*;
#(
    parameter int LINES        = DEF_LINES,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dmchc_req_t             request,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  dmchc_cmd_t             cmd,
    output dmchc_status_t          status,
    output logic                   done,
    output dmchc_resp_t            result
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int ENTRY_W = TAG_W + 1;
    localparam int FOLD_W = SEL_W + 14;
    localparam logic [32:0] ADDR_MASK_WIDE = (33'd1 << ADDRESS_BITS) - 33'd1;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_MASK_WIDE[ADDR_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / LINES);
    localparam logic [FOLD_W-1:0] LINES_F = FOLD_W'(LINES);
    localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(LINES - 1);

    // configuration registers
    logic [IDX_FIELD_W-1:0] index_bits_reg;
    logic [WOFS_W-1:0]      word_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg  <= INDEX_BITS_RESET;
            word_offset_reg <= WORD_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INDEX_BITS:  index_bits_reg  <= cfg_data[IDX_FIELD_W-1:0];
                REG_WORD_OFFSET: word_offset_reg <= cfg_data[WOFS_W-1:0];
            endcase
        end
    end

    // captured request
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= request.address & ADDR_MASK;
        end
    end

    assign status.flush_req = (request.opcode == OP_FLUSH);

    // address split: drop offsets, mask the index bits
    logic [ADDR_W-1:0]      block_full;
    logic [IDX_FIELD_W-1:0] shift_amt;
    logic [SEL_W:0]         sel_mask;
    logic [TAG_W-1:0]       tag_reg;
    logic [SEL_W-1:0]       sel_reg;

    assign shift_amt  = IDX_FIELD_W'(word_offset_reg) + IDX_FIELD_W'(2);
    assign block_full = addr_reg >> shift_amt;
    assign sel_mask   = ((SEL_W+1)'(1) << index_bits_reg) - (SEL_W+1)'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.split)
        begin
            tag_reg <= block_full[TAG_W-1:0];
            sel_reg <= block_full[SEL_W-1:0] & sel_mask[SEL_W-1:0];
        end
    end

    // quotient estimate by reciprocal multiply
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            prod_reg <= PROD_W'(sel_reg) * PROD_W'(RECIP);
        end
    end

    // remainder estimate, at most one line count too large
    logic [SEL_W:0]    quot;
    logic [FOLD_W-1:0] fold_diff;
    logic [FOLD_W-1:0] rem_raw_reg;

    assign quot      = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign fold_diff = FOLD_W'(sel_reg) - FOLD_W'(quot) * LINES_F;

    always_ff @(posedge clk)
    begin
        if (cmd.fold)
        begin
            rem_raw_reg <= fold_diff;
        end
    end

    // final correction gives the line number
    logic [FOLD_W-1:0] rem_fixed;
    logic [IDX_W-1:0]  line_idx;
    logic [IDX_W-1:0]  line_reg;

    assign rem_fixed = (rem_raw_reg >= LINES_F) ? rem_raw_reg - LINES_F : rem_raw_reg;
    assign line_idx  = rem_fixed[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            line_reg <= line_idx;
        end
    end

    // clearing sweep counter
    logic [IDX_W-1:0] sweep_reg;
    logic [IDX_W-1:0] sweep_next;

    assign status.sweep_last = (sweep_reg == LAST_LINE);
    assign sweep_next = status.sweep_last ? '0 : sweep_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_reg <= sweep_next;
        end
    end

    // tag store: valid bit over the block number
    logic               hit;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;

    assign hit = ram_rd_data[TAG_W] && (ram_rd_data[TAG_W-1:0] == tag_reg);

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = line_reg;
        ram_wr_data = {1'b1, tag_reg};
        if (cmd.sweep)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_reg;
            ram_wr_data = '0;
        end
        else if (cmd.update && !hit)
        begin
            ram_wr_en = 1'b1;
        end
    end

    dmchc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINES),
        .AW    (IDX_W)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.lookup),
        .rd_addr (line_idx),
        .rd_data (ram_rd_data)
    );

    // saturating hit and miss counters
    logic [COUNT_W-1:0] hit_count_reg;
    logic [COUNT_W-1:0] hit_count_next;
    logic [COUNT_W-1:0] miss_count_reg;
    logic [COUNT_W-1:0] miss_count_next;

    always_comb
    begin
        hit_count_next  = hit_count_reg;
        miss_count_next = miss_count_reg;
        if (cmd.zero_counts)
        begin
            hit_count_next  = '0;
            miss_count_next = '0;
        end
        else if (cmd.update)
        begin
            if (hit)
            begin
                if (hit_count_reg != COUNT_MAX)
                begin
                    hit_count_next = hit_count_reg + COUNT_W'(1);
                end
            end
            else if (miss_count_reg != COUNT_MAX)
            begin
                miss_count_next = miss_count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
        end
        else
        begin
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
        end
    end

    // result register and strobe
    logic        done_reg;
    dmchc_resp_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update | cmd.finish_flush;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            result_reg.hit        <= hit;
            result_reg.hit_count  <= hit_count_next;
            result_reg.miss_count <= miss_count_next;
        end
        else if (cmd.finish_flush)
        begin
            result_reg.hit        <= 1'b0;
            result_reg.hit_count  <= hit_count_reg;
            result_reg.miss_count <= miss_count_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/dmchc_ctrl.sv]
// controller: sequences the clearing sweep and the lookup steps
// depends on dmchc_pkg
module dmchc_ctrl
    import dmchc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dmchc_status_t status,
    output logic          busy,
    output dmchc_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SPLIT  = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_FOLD   = 3'd4;
    localparam logic [2:0] S_LOOKUP = 3'd5;
    localparam logic [2:0] S_CHECK  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       flush_reg;
    logic       flush_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.finish_flush = flush_reg;
                    flush_next       = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.flush_req)
                    begin
                        cmd.zero_counts = 1'b1;
                        flush_next      = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers; reset starts with a clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[bench/direct_mapped_cache_hit_counter_tb.sv]
// self-checking testbench for the direct-mapped cache hit counter
// depends on dmchc_pkg and direct_mapped_cache_hit_counter; reads no files

// tag store predictor and result checker
class cache_hit_board;
    localparam int NLINES = dmchc_pkg::DEF_LINES;

    bit                             line_valid [NLINES];
    logic [dmchc_pkg::TAG_W-1:0]    line_tag [NLINES];
    logic [dmchc_pkg::COUNT_W-1:0]  hits_total;
    logic [dmchc_pkg::COUNT_W-1:0]  misses_total;
    int unsigned                    index_bits;
    int unsigned                    word_offset_bits;
    dmchc_pkg::dmchc_resp_t         pending_results [$];
    int                             errors;
    int                             results_seen;
    int                             hits_seen;
    int                             misses_seen;
    int                             flushes_seen;

    function new();
        foreach (line_valid[i])
        begin
            line_valid[i] = 1'b0;
        end
        hits_total       = '0;
        misses_total     = '0;
        index_bits       = dmchc_pkg::INDEX_BITS_RESET;
        word_offset_bits = dmchc_pkg::WORD_OFFSET_RESET;
        errors           = 0;
        results_seen     = 0;
        hits_seen        = 0;
        misses_seen      = 0;
        flushes_seen     = 0;
    endfunction

    // register write, with the same field widths as the block
    function void write_reg(logic [dmchc_pkg::CFG_INDEX_W-1:0] idx,
                            logic [dmchc_pkg::CFG_DATA_W-1:0] data);
        if (idx == dmchc_pkg::REG_INDEX_BITS)
        begin
            index_bits = data;
        end
        else
        begin
            word_offset_bits = data[dmchc_pkg::WOFS_W-1:0];
        end
    endfunction

    // predict the result of one accepted transaction
    function void note_request(dmchc_pkg::dmchc_req_t req);
        dmchc_pkg::dmchc_resp_t exp_res;
        logic [31:0]            block;
        logic [31:0]            mask;
        int unsigned            line;
        exp_res.hit = 1'b0;
        if (req.opcode == dmchc_pkg::OP_FLUSH)
        begin
            foreach (line_valid[i])
            begin
                line_valid[i] = 1'b0;
            end
            hits_total   = '0;
            misses_total = '0;
            flushes_seen++;
        end
        else
        begin
            block = req.address >> (2 + word_offset_bits);
            mask  = (32'd1 << index_bits) - 32'd1;
            // lines beyond the store wrap; the full block number guards aliases
            line  = (block & mask) % NLINES;
            if (line_valid[line] && line_tag[line] == block[dmchc_pkg::TAG_W-1:0])
            begin
                exp_res.hit = 1'b1;
                if (hits_total != dmchc_pkg::COUNT_MAX)
                begin
                    hits_total = hits_total + 1;
                end
                hits_seen++;
            end
            else
            begin
                if (misses_total != dmchc_pkg::COUNT_MAX)
                begin
                    misses_total = misses_total + 1;
                end
                line_valid[line] = 1'b1;
                line_tag[line]   = block[dmchc_pkg::TAG_W-1:0];
                misses_seen++;
            end
        end
        exp_res.hit_count  = hits_total;
        exp_res.miss_count = misses_total;
        pending_results.push_back(exp_res);
    endfunction

    // one line per mismatch
    task report_mismatch(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // compare a result transaction against the oldest prediction
    task check_result(dmchc_pkg::dmchc_resp_t got);
        dmchc_pkg::dmchc_resp_t exp_res;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with none pending: hit=%0b hits=%0d misses=%0d",
                                      got.hit, got.hit_count, got.miss_count));
            return;
        end
        exp_res = pending_results.pop_front();
        results_seen++;
        if (got.hit !== exp_res.hit)
        begin
            report_mismatch($sformatf("result %0d hit: got %0b expected %0b",
                                      results_seen, got.hit, exp_res.hit));
        end
        if (got.hit_count !== exp_res.hit_count)
        begin
            report_mismatch($sformatf("result %0d hit_count: got %0d expected %0d",
                                      results_seen, got.hit_count, exp_res.hit_count));
        end
        if (got.miss_count !== exp_res.miss_count)
        begin
            report_mismatch($sformatf("result %0d miss_count: got %0d expected %0d",
                                      results_seen, got.miss_count, exp_res.miss_count));
        end
    endtask
endclass

module direct_mapped_cache_hit_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dmchc_pkg::*;

    localparam int ACCESS_LATENCY = 6;
    localparam int DRAIN_CYCLES   = 2 * ACCESS_LATENCY;
    // nothing is accepted while a flush or the reset sweep runs
    localparam int STALL_LIMIT    = 8 * (DEF_LINES + 16);
    localparam int GEOMETRIES     = 7;
    localparam int PHASE_ITEMS    = 100;
    localparam int POOL_DEPTH     = 24;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    dmchc_req_t             request;
    logic                   done;
    dmchc_resp_t            result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cache_hit_board         board;
    logic [ADDR_W-1:0]      addr_pool [$];
    logic [CFG_DATA_W-1:0]  geo_index [GEOMETRIES];
    logic [CFG_DATA_W-1:0]  geo_wofs [GEOMETRIES];
    int                     stall_cycles;
    bit                     gaps_enabled;

    direct_mapped_cache_hit_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // result monitor; results cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check_result(result);
        end
    end

    // watchdog on cycles with no transaction moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("direct_mapped_cache_hit_counter regression: fail");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // hold start until the block takes the transaction
    task automatic send_request(input dmchc_req_t req);
        start   <= 1'b1;
        request <= req;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        board.note_request(req);
    endtask

    task automatic issue(input logic op, input logic [ADDR_W-1:0] addr);
        dmchc_req_t req;
        req.opcode  = op;
        req.address = addr;
        send_request(req);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (gaps_enabled && $urandom_range(99) < 30)
        begin
            hold_off($urandom_range(9, 1));
        end
    endtask

    // let every pending result come back, then settle
    task automatic drain();
        start <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both split registers while the block is idle
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] idx_val,
                                input logic [CFG_DATA_W-1:0] wofs_val);
        cfg_write <= 1'b1;
        cfg_index <= REG_INDEX_BITS;
        cfg_data  <= idx_val;
        @(posedge clk);
        board.write_reg(REG_INDEX_BITS, idx_val);
        cfg_index <= REG_WORD_OFFSET;
        cfg_data  <= wofs_val;
        @(posedge clk);
        board.write_reg(REG_WORD_OFFSET, wofs_val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // mostly revisits of earlier blocks, plus conflicts, aliases and flushes
    function automatic dmchc_req_t next_request();
        dmchc_req_t        req;
        int unsigned       pick;
        int unsigned       low_bits;
        int unsigned       tag_shift;
        int unsigned       alias_bit;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] low_mask;
        pick        = $urandom_range(99);
        req.opcode  = OP_ACCESS;
        req.address = $urandom();
        low_bits    = 2 + board.word_offset_bits;
        tag_shift   = low_bits + board.index_bits;
        low_mask    = (32'd1 << low_bits) - 32'd1;
        if (pick < 3)
        begin
            req.opcode = OP_FLUSH;
        end
        else if (pick < 80 && addr_pool.size() != 0)
        begin
            base = addr_pool[$urandom_range(addr_pool.size() - 1)];
            if (pick < 55)
            begin
                // same block, any word and byte within it
                req.address = (base & ~low_mask) | (req.address & low_mask);
            end
            else if (pick < 70)
            begin
                // same line, different tag
                req.address = base ^ ((req.address | 32'd1) << tag_shift);
            end
            else if (board.index_bits > 9)
            begin
                // index bits above the store size wrap onto the same line
                alias_bit   = $urandom_range(board.index_bits - 1, 9);
                req.address = base ^ (32'd1 << (low_bits + alias_bit));
            end
            else
            begin
                req.address = base;
            end
        end
        else
        begin
            addr_pool.push_back(req.address);
            if (addr_pool.size() > POOL_DEPTH)
            begin
                void'(addr_pool.pop_front());
            end
        end
        return req;
    endfunction

    // stimulus
    initial
    begin
        dmchc_req_t req;
        board     = new();
        geo_index = '{4'd0, 4'd15, 4'd9, 4'd3, 4'd12, 4'd6, 4'd9};
        geo_wofs  = '{4'd0, 4'd15, 4'd4, 4'd1, 4'd2, 4'd3, 4'd7};
        rst_n        <= 1'b0;
        start        <= 1'b0;
        request      <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        gaps_enabled = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // wait out the clearing sweep after reset
        @(posedge clk);
        while (busy) @(posedge clk);

        // directed: reset split, address extremes, conflicts and flushes
        issue(OP_ACCESS, 32'h0000_0000);
        issue(OP_ACCESS, 32'h0000_0000);
        issue(OP_ACCESS, 32'h0000_0003);
        issue(OP_ACCESS, 32'h0000_0004);
        issue(OP_ACCESS, 32'hFFFF_FFFF);
        issue(OP_ACCESS, 32'hFFFF_FFFF);
        issue(OP_ACCESS, 32'hFFFF_FFFC);
        issue(OP_ACCESS, 32'h0000_0800);
        issue(OP_ACCESS, 32'h0000_0000);
        issue(OP_ACCESS, 32'h8000_0000);
        issue(OP_ACCESS, 32'h8000_0001);
        issue(OP_FLUSH,  32'hFFFF_FFFF);
        issue(OP_ACCESS, 32'h0000_0000);
        issue(OP_ACCESS, 32'h0000_0000);
        issue(OP_FLUSH,  32'h0000_0000);
        issue(OP_FLUSH,  32'h5555_AAAA);
        issue(OP_ACCESS, 32'h7FFF_FFFF);
        issue(OP_ACCESS, 32'h7FFF_FFFC);
        issue(OP_ACCESS, 32'hFFFF_FFFC);
        drain();

        // random phases, one per split setting; lines carry over between them
        for (int phase = 0; phase < GEOMETRIES; phase++)
        begin
            set_geometry(geo_index[phase], geo_wofs[phase]);
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                if (item % 25 == 0)
                begin
                    gaps_enabled = (phase != GEOMETRIES - 1) && ($urandom_range(1) == 1);
                end
                req = next_request();
                send_request(req);
                maybe_gap();
            end
            drain();
        end

        $display("checked %0d results: %0d accesses (%0d hits, %0d misses), %0d flushes",
                 board.results_seen, board.hits_seen + board.misses_seen,
                 board.hits_seen, board.misses_seen, board.flushes_seen);
        $display("split settings: reset default plus %0d, index widths 0..15, offsets 0..7",
                 GEOMETRIES);
        if (board.errors == 0 && board.pending_results.size() == 0)
        begin
            $display("direct_mapped_cache_hit_counter regression: pass");
        end
        else
        begin
            $display("%0d mismatches", board.errors);
            $display("direct_mapped_cache_hit_counter regression: fail");
        end
        $finish;
    end
endmodule
